FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, constants and the CRC step shared by the deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

   localparam int DefMaxPayload = 64;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam logic [15:0] CrcTop  = 16'h8000;

   localparam logic [7:0] SyncFirstReset   = 8'hAA;
   localparam logic [7:0] SyncSecondReset  = 8'h55;
   localparam logic [6:0] LengthLimitReset = 7'd64;

   typedef enum logic [1:0] {
      REG_SYNC_FIRST   = 2'd0,
      REG_SYNC_SECOND  = 2'd1,
      REG_LENGTH_LIMIT = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_CRC_ERR = 1'b1
   } kind_type;

   typedef struct packed {
      logic       en;
      logic [1:0] index;
      logic [7:0] data;
   } cfg_wr_type;

   typedef struct packed {
      logic       en;
      logic [5:0] addr;
      logic [7:0] data;
   } pay_wr_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  len;
      logic [31:0] good;
      logic [31:0] bad;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // One byte of CRC-16/CCITT-FALSE, MSB first.
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTop) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Header parser, payload writer, CRC check and frame counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_front #(
   parameter int MAX_PAYLOAD = dfr_pkg::DefMaxPayload
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dfr_pkg::cfg_wr_type      cfg_wr,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_byte,
   input  logic                     back_hold,
   input  dfr_pkg::fifo_status_type fifo_status,
   output logic                     job_push,
   output dfr_pkg::job_type         job,
   output dfr_pkg::pay_wr_type      pay_wr
);
   import dfr_pkg::*;

   localparam logic [6:0] MaxLen = 7'(MAX_PAYLOAD);

   typedef enum logic [6:0] {
      F_SYNC1   = 7'b0000001,
      F_SYNC2   = 7'b0000010,
      F_LEN_LO  = 7'b0000100,
      F_LEN_HI  = 7'b0001000,
      F_PAYLOAD = 7'b0010000,
      F_CRC_LO  = 7'b0100000,
      F_CRC_HI  = 7'b1000000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  len_ff, len_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;
   logic [7:0]  sync1_ff, sync1_in;
   logic [7:0]  sync2_ff, sync2_in;
   logic [6:0]  limit_ff, limit_in;

   logic       accept;
   logic [6:0] eff_limit;
   logic       crc_ok;

   assign eff_limit = (limit_ff > MaxLen) ? MaxLen : limit_ff;
   assign crc_ok    = ({req_byte, crc_lo_ff} == crc_ff);

   // Payload bytes wait while any older verdict is still queued or draining;
   // the closing CRC byte waits for room in the job queue.
   always_comb begin
      req_ready = 1'b1;
      if (state_ff == F_PAYLOAD && back_hold) begin
         req_ready = 1'b0;
      end
      if (state_ff == F_CRC_HI && fifo_status.full) begin
         req_ready = 1'b0;
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      sync1_in = sync1_ff;
      sync2_in = sync2_ff;
      limit_in = limit_ff;
      if (cfg_wr.en) begin
         unique case (reg_index_type'(cfg_wr.index))
            REG_SYNC_FIRST:   sync1_in = cfg_wr.data;
            REG_SYNC_SECOND:  sync2_in = cfg_wr.data;
            REG_LENGTH_LIMIT: limit_in = cfg_wr.data[6:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      len_lo_in = len_lo_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      job_push  = 1'b0;
      job.kind  = crc_ok ? KIND_PAYLOAD : KIND_CRC_ERR;
      job.len   = len_ff;
      job.good  = crc_ok ? good_ff + 32'd1 : good_ff;
      job.bad   = crc_ok ? bad_ff : bad_ff + 32'd1;
      pay_wr.en   = 1'b0;
      pay_wr.addr = cnt_ff[5:0];
      pay_wr.data = req_byte;
      if (accept) begin
         unique case (state_ff)
            F_SYNC1: begin
               state_in = (req_byte == sync1_ff) ? F_SYNC2 : F_SYNC1;
            end
            F_SYNC2: begin
               if (req_byte == sync2_ff) begin
                  state_in = F_LEN_LO;
               end else begin
                  state_in = (req_byte == sync1_ff) ? F_SYNC2 : F_SYNC1;
               end
            end
            F_LEN_LO: begin
               len_lo_in = req_byte;
               state_in  = F_LEN_HI;
            end
            F_LEN_HI: begin
               if (req_byte == 8'h00 && len_lo_ff != 8'h00 &&
                   len_lo_ff <= {1'b0, eff_limit}) begin
                  len_in   = len_lo_ff[6:0];
                  crc_in   = CrcInit;
                  cnt_in   = 7'd0;
                  state_in = F_PAYLOAD;
               end else begin
                  state_in = F_SYNC1;
               end
            end
            F_PAYLOAD: begin
               pay_wr.en = 1'b1;
               crc_in    = crc_next(crc_ff, req_byte);
               cnt_in    = cnt_ff + 7'd1;
               if (cnt_ff + 7'd1 == len_ff) begin
                  state_in = F_CRC_LO;
               end
            end
            F_CRC_LO: begin
               crc_lo_in = req_byte;
               state_in  = F_CRC_HI;
            end
            F_CRC_HI: begin
               job_push = 1'b1;
               good_in  = job.good;
               bad_in   = job.bad;
               state_in = F_SYNC1;
            end
            default: state_in = F_SYNC1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_SYNC1;
         good_ff  <= 32'd0;
         bad_ff   <= 32'd0;
         sync1_ff <= SyncFirstReset;
         sync2_ff <= SyncSecondReset;
         limit_ff <= LengthLimitReset;
         crc_ff   <= CrcInit;
      end else begin
         state_ff <= state_in;
         good_ff  <= good_in;
         bad_ff   <= bad_in;
         sync1_ff <= sync1_in;
         sync2_ff <= sync2_in;
         limit_ff <= limit_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      len_ff    <= len_in;
      len_lo_ff <= len_lo_in;
      crc_lo_ff <= crc_lo_in;
   end

endmodule

FILE: hw/rtl/dfr_job_fifo.sv
// ----------------------------------------------------------------------------
// dfr_job_fifo
// Two-entry queue of frame verdicts between the parser and the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_job_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dfr_pkg::job_type         push_job,
   input  logic                     pop,
   output dfr_pkg::job_type         head_job,
   output dfr_pkg::fifo_status_type status
);
   import dfr_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hw/rtl/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Payload buffer and result sequencer that drains one verdict at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_back #(
   parameter int MAX_PAYLOAD = dfr_pkg::DefMaxPayload
) (
   input  logic                clock,
   input  logic                reset,
   input  dfr_pkg::pay_wr_type pay_wr,
   input  logic                job_ready,
   input  dfr_pkg::job_type    head_job,
   output logic                job_pop,
   output logic                active,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dfr_pkg::kind_type   rsp_kind,
   output logic                rsp_last,
   output logic [7:0]          rsp_byte,
   output logic [5:0]          rsp_index,
   output logic [6:0]          rsp_len,
   output logic [31:0]         rsp_good,
   output logic [31:0]         rsp_bad
);
   import dfr_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_SHOW = 3'b100
   } back_state_type;

   logic [7:0] mem [MAX_PAYLOAD];
   logic [7:0] mem_q_ff;

   back_state_type state_ff, state_in;
   job_type    job_ff, job_in;
   logic [6:0] idx_ff, idx_in;
   logic       rd_en;
   logic       final_byte;

   assign final_byte = (idx_ff + 7'd1 == job_ff.len);
   assign active     = (state_ff != B_IDLE);
   assign rd_en      = (state_ff == B_READ);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      job_pop  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (job_ready) begin
               job_pop  = 1'b1;
               job_in   = head_job;
               idx_in   = 7'd0;
               state_in = (head_job.kind == KIND_CRC_ERR) ? B_SHOW : B_READ;
            end
         end
         B_READ: state_in = B_SHOW;
         B_SHOW: begin
            if (rsp_ready) begin
               if (job_ff.kind == KIND_CRC_ERR || final_byte) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + 7'd1;
                  state_in = B_READ;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (pay_wr.en) begin
         mem[pay_wr.addr[AW-1:0]] <= pay_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid = (state_ff == B_SHOW);
   assign rsp_kind  = job_ff.kind;
   assign rsp_last  = (job_ff.kind == KIND_CRC_ERR) || final_byte;
   assign rsp_byte  = (job_ff.kind == KIND_CRC_ERR) ? 8'h00 : mem_q_ff;
   assign rsp_index = (job_ff.kind == KIND_CRC_ERR) ? 6'd0 : idx_ff[5:0];
   assign rsp_len   = job_ff.len;
   assign rsp_good  = job_ff.good;
   assign rsp_bad   = job_ff.bad;

endmodule

FILE: hw/rtl/crc_framed_byte_deframer_unit.sv
// ----------------------------------------------------------------------------
// crc_framed_byte_deframer_unit
// Recovers sync/length/CRC-16 framed payloads from a stream of serial bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Moves
//   req_     in         req_tvalid/tready    one received byte per item
//   rsp_     out        rsp_tvalid/tready    one payload byte or CRC error item
//   csr_     in         csr_valid/ready      register index and write data
//
// Header, CRC and sync bytes are taken at one item per cycle; the parser
// updates the CRC within the same cycle it accepts a payload byte.
// Payload bytes stall while any earlier verdict is still queued or being
// released from the shared payload buffer, and the final CRC byte stalls
// while the two-entry verdict queue is full.
// A verdict is taken from the queue while the output side is idle. An error
// item then goes straight to the output, while a good frame first passes a
// registered buffer read; each further payload item again passes that read
// before it is shown. After the last item of a run the output side returns
// to idle and drops rsp_tvalid.
// A stalled rsp_tready holds the result in place while the parser keeps
// taking header bytes.
// Reset is synchronous and active high; the buffer needs no clearing pass
// because every byte released was written during the same frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module crc_framed_byte_deframer_unit #(
   parameter int MAX_PAYLOAD = dfr_pkg::DefMaxPayload
) (
   input  logic        clock,
   input  logic        reset,
   // Input bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                    // [20:14] frame_length, [52:21] good_frames,
                                    // [84:53] bad_crc_frames, [87:85] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,   // last
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import dfr_pkg::*;

   cfg_wr_type      cfg_wr;
   pay_wr_type      pay_wr;
   job_type         push_job;
   job_type         head_job;
   fifo_status_type fifo_status;
   logic            job_push;
   logic            job_pop;
   logic            back_active;
   logic            back_hold;
   kind_type        rsp_kind;
   logic [7:0]      rsp_byte;
   logic [5:0]      rsp_index;
   logic [6:0]      rsp_len;
   logic [31:0]     rsp_good;
   logic [31:0]     rsp_bad;

   // Registers are always writable; the user keeps writes to idle, unenforced.
   assign csr_ready    = 1'b1;
   assign cfg_wr.en    = csr_valid;
   assign cfg_wr.index = csr_index;
   assign cfg_wr.data  = csr_data;

   // The payload buffer is busy as long as any verdict is queued or draining.
   assign back_hold = back_active || !fifo_status.empty;

   dfr_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_wr      (cfg_wr),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_byte    (req_tdata),
      .back_hold   (back_hold),
      .fifo_status (fifo_status),
      .job_push    (job_push),
      .job         (push_job),
      .pay_wr      (pay_wr)
   );

   dfr_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (fifo_status)
   );

   dfr_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pay_wr    (pay_wr),
      .job_ready (!fifo_status.empty),
      .head_job  (head_job),
      .job_pop   (job_pop),
      .active    (back_active),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_kind),
      .rsp_last  (rsp_tlast),
      .rsp_byte  (rsp_byte),
      .rsp_index (rsp_index),
      .rsp_len   (rsp_len),
      .rsp_good  (rsp_good),
      .rsp_bad   (rsp_bad)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {3'b000, rsp_bad, rsp_good, rsp_len, rsp_index, rsp_byte};

   // A payload byte is never written while an older frame may still read it.
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, pay_wr.en, !back_hold)
   // A verdict pushed into the queue is visible the next cycle.
   `ASSERT_NEXT(a_push_lands, clock, reset, job_push && !fifo_status.full, !fifo_status.empty)
   // After the final item of a run, the output side idles and drops rsp_tvalid.
   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)
   // A result is only shown while the output side is busy with a verdict.
   `ASSERT_IMPLY(a_valid_active, clock, reset, rsp_tvalid, back_active)

endmodule

FILE: test/frame_release_checker.sv
// ----------------------------------------------------------------------------
// frame_release_checker
// Watches the byte, result and register channels of the deframer, predicts
// the released payload and CRC error items, and compares them as they leave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deframer_tb_pkg;

   localparam logic [15:0] CcittInit  = 16'hFFFF;
   localparam logic [15:0] CcittPoly  = 16'h1021;
   localparam int          PayloadCap = 64;

   // One byte of CRC-16/CCITT-FALSE, most significant bit first.
   function automatic logic [15:0] ccitt_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {b, 8'h00};
      for (int n = 0; n < 8; n++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CcittPoly;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

module frame_release_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);
   import dfr_pkg::*;
   import deframer_tb_pkg::*;

   localparam int HeaderBytes = 4;

   typedef struct {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [5:0]  byte_index;
      logic [6:0]  frame_length;
      logic        last;
      logic [31:0] good_frames;
      logic [31:0] bad_crc_frames;
   } release_item_type;

   release_item_type expected_releases_q[$];

   logic [7:0]  sync_first_r;
   logic [7:0]  sync_second_r;
   logic [6:0]  length_limit_r;

   int          parse_pos;
   logic [7:0]  len_low;
   logic [6:0]  frame_len;
   logic [7:0]  payload_buf [PayloadCap];
   logic [15:0] crc_acc;
   logic [7:0]  crc_low;
   logic [31:0] good_total;
   logic [31:0] crc_err_total;

   task automatic report_mismatch(input string what);
      $display("%0t: release mismatch, %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   task automatic parse_rx_byte(input logic [7:0] c);
      logic [15:0]      hdr_len;
      int               eff;
      release_item_type r;
      case (parse_pos)
         0: begin
            parse_pos = (c == sync_first_r) ? 1 : 0;
         end
         1: begin
            if (c == sync_second_r) begin
               parse_pos = 2;
            end else begin
               parse_pos = (c == sync_first_r) ? 1 : 0;
            end
         end
         2: begin
            len_low   = c;
            parse_pos = 3;
         end
         3: begin
            hdr_len = {c, len_low};
            eff     = (length_limit_r > PayloadCap) ? PayloadCap : length_limit_r;
            if (hdr_len == 0 || hdr_len > eff) begin
               parse_pos = 0;
            end else begin
               frame_len = hdr_len[6:0];
               crc_acc   = CcittInit;
               parse_pos = HeaderBytes;
            end
         end
         default: begin
            if (parse_pos < HeaderBytes + frame_len) begin
               payload_buf[parse_pos - HeaderBytes] = c;
               crc_acc = ccitt_crc_byte(crc_acc, c);
               parse_pos++;
            end else if (parse_pos == HeaderBytes + frame_len) begin
               crc_low = c;
               parse_pos++;
            end else begin
               parse_pos = 0;
               r.frame_length = frame_len;
               if ({c, crc_low} == crc_acc) begin
                  good_total++;
                  for (int k = 0; k < frame_len; k++) begin
                     r.kind           = KIND_PAYLOAD;
                     r.data_byte      = payload_buf[k];
                     r.byte_index     = k[5:0];
                     r.last           = (k + 1 == frame_len);
                     r.good_frames    = good_total;
                     r.bad_crc_frames = crc_err_total;
                     expected_releases_q.push_back(r);
                  end
               end else begin
                  crc_err_total++;
                  r.kind           = KIND_CRC_ERR;
                  r.data_byte      = 8'h00;
                  r.byte_index     = 6'd0;
                  r.last           = 1'b1;
                  r.good_frames    = good_total;
                  r.bad_crc_frames = crc_err_total;
                  expected_releases_q.push_back(r);
               end
            end
         end
      endcase
   endtask

   task automatic compare_release();
      release_item_type want;
      if (expected_releases_q.size() == 0) begin
         report_mismatch($sformatf("unexpected item, tdata 0x%0h", rsp_tdata));
      end else begin
         want = expected_releases_q.pop_front();
         check_field("kind", rsp_tuser, want.kind);
         check_field("data_byte", rsp_tdata[7:0], want.data_byte);
         check_field("byte_index", rsp_tdata[13:8], want.byte_index);
         check_field("frame_length", rsp_tdata[20:14], want.frame_length);
         check_field("good_frames", rsp_tdata[52:21], want.good_frames);
         check_field("bad_crc_frames", rsp_tdata[84:53], want.bad_crc_frames);
         check_field("tdata padding", rsp_tdata[87:85], 3'b000);
         check_field("last", rsp_tlast, want.last);
      end
   endtask

   // Everything is sampled at the rising edge; the stimulus side only moves
   // on the falling edge, so no ordering inside a time step matters here.
   always @(posedge clock) begin
      if (reset) begin
         sync_first_r   = SyncFirstReset;
         sync_second_r  = SyncSecondReset;
         length_limit_r = LengthLimitReset;
         parse_pos      = 0;
         len_low        = 8'h00;
         frame_len      = 7'd0;
         crc_acc        = CcittInit;
         crc_low        = 8'h00;
         good_total     = 32'd0;
         crc_err_total  = 32'd0;
         expected_releases_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_release();
         end
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_SYNC_FIRST:   sync_first_r   = csr_data;
               REG_SYNC_SECOND:  sync_second_r  = csr_data;
               REG_LENGTH_LIMIT: length_limit_r = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
         end
      end
      pending_count = expected_releases_q.size();
   end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives serial bytes and register writes into the frame deframer under
// shifting back-pressure and reports whether every released item matched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dfr_pkg::*;
   import deframer_tb_pkg::*;

   // Generous bound on the whole run, far above the slowest legal schedule.
   localparam int CycleLimit = 500000;
   // Idle cycles allowed after the last expected item before a register
   // write or the verdict.
   localparam int SettleCycles = 8;
   localparam int TailCycles   = 50;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;    // [7:0] data_byte, [13:8] byte_index,
                              // [20:14] frame_length, [52:21] good_frames,
                              // [84:53] bad_crc_frames, [87:85] zero
   logic        rsp_tuser;    // [0] kind
   logic        rsp_tlast;    // last
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          byte_count = 0;
   int          sender_idle_pct = 0;
   int          recv_stall_pct = 0;

   // Register values as last written, used only to shape well-formed frames.
   logic [7:0]  cur_sf = SyncFirstReset;
   logic [7:0]  cur_ss = SyncSecondReset;
   logic [6:0]  cur_lim = LengthLimitReset;

   crc_framed_byte_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frame_release_checker release_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver decides on every falling edge whether it takes an item at
   // the next rising edge; a stall percentage of zero means it never stalls.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int effective_limit();
      return (cur_lim > PayloadCap) ? PayloadCap : int'(cur_lim);
   endfunction

   // Offers one byte, with random idle cycles ahead of it in sender-idle
   // phases. tvalid stays high on return so back-to-back bytes have no gap.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      byte_count++;
      @(negedge clock);
   endtask

   // Sends the header; the payload and CRC follow only when the length will
   // be accepted, since a rejected length drops the parser back to hunting.
   task automatic send_frame(input logic [15:0] length, input logic [7:0] body [$],
                             input bit corrupt_crc);
      logic [15:0] crc;
      send_byte(cur_sf);
      send_byte(cur_ss);
      send_byte(length[7:0]);
      send_byte(length[15:8]);
      if (length != 0 && length <= effective_limit()) begin
         crc = CcittInit;
         foreach (body[k]) begin
            crc = ccitt_crc_byte(crc, body[k]);
            send_byte(body[k]);
         end
         if (corrupt_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
         end
         send_byte(crc[7:0]);
         send_byte(crc[15:8]);
      end
   endtask

   // Holds the sender off until every predicted item has left the block,
   // then gives it a few cycles to finish whatever it is still doing.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic put_reg(input reg_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // The unused index gets random data as well; the block must ignore it.
   task automatic write_regs(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [6:0] lim);
      put_reg(REG_SYNC_FIRST, sf);
      put_reg(REG_SYNC_SECOND, ss);
      put_reg(REG_LENGTH_LIMIT, {1'b0, lim});
      put_reg(REG_UNUSED, 8'($urandom));
      csr_valid <= 1'b0;
      cur_sf  = sf;
      cur_ss  = ss;
      cur_lim = lim;
   endtask

   // One phase of random traffic under a fixed register setting and idle
   // pattern. Most of it is well-formed frames with random payload so the
   // parser reaches the release path; the rest is bad lengths, line noise
   // and headers broken after the first sync byte.
   task automatic run_phase(input int sender_pct, input int recv_pct,
                            input logic [7:0] sf, input logic [7:0] ss,
                            input logic [6:0] lim, input int budget,
                            input bit pause_midway, input bit open_full);
      int          start;
      int          eff;
      int          len;
      int          pick;
      bit          paused;
      logic [15:0] bad_len;
      logic [7:0]  body [$];
      wait_drained();
      write_regs(sf, ss, lim);
      sender_idle_pct = sender_pct;
      recv_stall_pct  = recv_pct;
      eff    = effective_limit();
      paused = 1'b0;
      // If asked and at full limit, open with one frame that fills the buffer.
      if (open_full && eff == PayloadCap) begin
         repeat (PayloadCap) body.push_back(8'($urandom));
         send_frame(16'(PayloadCap), body, 1'b0);
      end
      start  = byte_count;
      while (byte_count - start < budget) begin
         if (pause_midway && !paused && (byte_count - start) >= budget / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         body.delete();
         pick = $urandom_range(99);
         if (pick < 70) begin
            if (eff == 0) begin
               len = $urandom_range(1, 4);
            end else if ($urandom_range(9) == 0) begin
               len = $urandom_range(1, eff);
            end else begin
               len = $urandom_range(1, (eff < 8) ? eff : 8);
            end
            repeat (len) body.push_back(8'($urandom));
            send_frame(16'(len), body, $urandom_range(99) < 15);
         end else if (pick < 80) begin
            case ($urandom_range(2))
               0: bad_len = 16'h0000;
               1: bad_len = 16'($urandom_range(eff + 1, 255));
               default: bad_len = {8'($urandom_range(1, 255)), 8'($urandom)};
            endcase
            send_frame(bad_len, body, 1'b0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            send_byte(cur_sf);
            send_byte(($urandom_range(1) == 1) ? cur_sf : 8'($urandom));
         end
      end
   endtask

   initial begin
      logic [7:0] body [$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_index  = REG_SYNC_FIRST;
      csr_data   = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset register values.
      // A byte that is not the first sync byte is dropped.
      send_byte(8'h00);
      // A repeated first sync byte restarts the header; then a second byte
      // that matches neither sync value sends the parser back to hunting.
      send_byte(cur_sf);
      send_byte(cur_sf);
      send_byte(8'h00);
      // Good two-byte frame carrying both byte extremes.
      body = '{8'h00, 8'hFF};
      send_frame(16'd2, body, 1'b0);
      // Zero length, then a length with a nonzero high byte: both are
      // dropped silently at the header.
      body.delete();
      send_frame(16'h0000, body, 1'b0);
      send_frame(16'h0107, body, 1'b0);
      // A CRC mismatch gives one error item.
      body = '{8'h5A};
      send_frame(16'd1, body, 1'b1);
      // Leave a first sync byte pending so the next register write lands
      // in the middle of a header.
      send_byte(cur_sf);

      // Random phases, each with its own register setting and idle pattern.
      // The limit of zero rejects every frame; the limit of one keeps only
      // single-byte frames; 127 is clipped to the buffer size.
      run_phase(0, 0, 8'h00, 8'hFF, 7'd127, 12, 1'b0, 1'b0);
      run_phase(85, 0, 8'hFF, 8'h00, 7'd0, 8, 1'b0, 1'b0);
      run_phase(85, 0, 8'h3C, 8'hC3, 7'd1, 12, 1'b0, 1'b0);
      // This phase opens with a full-buffer frame under receiver stalls and
      // also parks the sender once until the result queue drains.
      run_phase(0, 85, SyncFirstReset, SyncSecondReset, LengthLimitReset, 20, 1'b1,
                1'b1);
      run_phase(21, 21, 8'($urandom), 8'($urandom), 7'($urandom_range(8, 127)), 12,
                1'b0, 1'b0);

      wait_drained();
      repeat (TailCycles) @(negedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
